### rtl/mvc_pkg.sv
package mvc_pkg;

  // Frame layout constants.
  localparam logic [7:0] MAGIC_V2      = 8'hFD;
  localparam logic [9:0] HEADER_LEN    = 10'd10;
  localparam logic [9:0] CHECKSUM_LEN  = 10'd2;
  localparam logic [9:0] SIGNATURE_LEN = 10'd13;
  localparam logic [8:0] POS_MAX       = 9'd511;
  localparam logic [15:0] CRC_SEED     = 16'hFFFF;

  // Verdict codes.
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_MAGIC     = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_CRC       = 3'd4;

  // Role of a byte within the frame, worked out by the front part.
  typedef struct packed {
    logic crc_data;  // byte goes into the running checksum
    logic fold;      // last payload byte: fold in the CRC-extra byte after it
    logic crc_lo;    // low byte of the received checksum
    logic crc_hi;    // high byte of the received checksum
  } byte_class_t;

  // One queued request from the front part to the back part.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [8:0]  pos;
    byte_class_t cls;
  } entry_t;

  // One X.25 / MCRF4XX checksum step over a byte.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

  // CRC-extra byte of the known messages; zero for an unknown id.
  function automatic logic [7:0] extra_for(input logic [23:0] id);
    logic [7:0] e;
    case (id)
      24'd0:   e = 8'd50;
      24'd1:   e = 8'd124;
      24'd24:  e = 8'd24;
      24'd31:  e = 8'd246;
      24'd33:  e = 8'd104;
      default: e = 8'd0;
    endcase
    return e;
  endfunction

endpackage

### rtl/mvc_front.sv
module mvc_front import mvc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output entry_t     push_entry
);

  logic [8:0] pos;
  logic [8:0] pos_next;
  logic [7:0] len;
  logic [7:0] len_next;
  logic [7:0] cur_len;
  logic [9:0] pos_w;
  logic [9:0] data_end;

  assign push = in_valid && !in_stall;

  // The length byte counts as known on the very cycle it arrives.
  assign cur_len  = (pos == 9'd1) ? data_byte : len;
  assign pos_w    = {1'b0, pos};
  assign data_end = HEADER_LEN - 10'd1 + {2'b00, cur_len};

  // Classify the byte by its position against the frame layout.
  always_comb begin
    push_entry.data         = data_byte;
    push_entry.last         = last_byte;
    push_entry.pos          = pos;
    push_entry.cls.crc_data = (pos != 9'd0) && (pos_w <= data_end);
    push_entry.cls.fold     = (pos_w == data_end);
    push_entry.cls.crc_lo   = (pos_w == data_end + 10'd1);
    push_entry.cls.crc_hi   = (pos_w == data_end + 10'd2);
  end

  // Position count and length copy; both clear at the end of a datagram.
  always_comb begin
    pos_next = pos;
    len_next = len;
    if (push) begin
      if (last_byte) begin
        pos_next = 9'd0;
        len_next = 8'd0;
      end else begin
        if (pos < POS_MAX) pos_next = pos + 9'd1;
        len_next = cur_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 9'd0;
      len <= 8'd0;
    end else begin
      pos <= pos_next;
      len <= len_next;
    end
  end

endmodule

### rtl/mvc_queue.sv
module mvc_queue import mvc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  output logic   q_valid,
  output entry_t q_entry,
  input  logic   pop
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_entry = slots[rd_ptr];

  // Payload slots hold no reset.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/mvc_back.sv
module mvc_back import mvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_ok,
  output logic [2:0]  error_code,
  output logic        crc_checked,
  output logic [7:0]  sequence_number,
  output logic [7:0]  system_id,
  output logic [7:0]  component_id,
  output logic [23:0] message_id,
  output logic [7:0]  payload_length,
  output logic        is_signed
);

  logic        magic_good;
  logic [7:0]  length_byte;
  logic [7:0]  incompat_bits;
  logic [7:0]  seq_reg;
  logic [7:0]  sys_reg;
  logic [7:0]  comp_reg;
  logic [23:0] msg_reg;
  logic [15:0] running_crc;
  logic [7:0]  received_low;
  logic        crc_match;

  logic [23:0] msg_next;
  logic [15:0] crc_one;
  logic [15:0] crc_two;
  logic [15:0] crc_next;
  logic        match_next;
  logic [9:0]  count;
  logic [9:0]  need;
  logic        known;
  logic [2:0]  err;
  logic        checked;

  // A byte that ends no datagram never waits for the output register.
  assign pop = q_valid && (!q_entry.last || !out_valid || !out_stall);

  // Message id bytes land as they arrive so the extra byte sees them at once.
  always_comb begin
    msg_next = msg_reg;
    case (q_entry.pos)
      9'd7:    msg_next[7:0]   = q_entry.data;
      9'd8:    msg_next[15:8]  = q_entry.data;
      9'd9:    msg_next[23:16] = q_entry.data;
      default: msg_next = msg_reg;
    endcase
  end

  // Checksum update: the byte, then the CRC-extra byte after the payload.
  always_comb begin
    crc_one = crc_step(running_crc, q_entry.data);
    crc_two = crc_step(crc_one, extra_for(msg_next));
    if (q_entry.pos == 9'd0) crc_next = CRC_SEED;
    else if (q_entry.cls.crc_data) crc_next = q_entry.cls.fold ? crc_two : crc_one;
    else crc_next = running_crc;
    match_next = q_entry.cls.crc_hi ? (running_crc == {q_entry.data, received_low})
                                    : crc_match;
  end

  // Verdict for a datagram that ends with this byte.
  always_comb begin
    count   = {1'b0, q_entry.pos} + 10'd1;
    need    = HEADER_LEN + {2'b00, length_byte} + CHECKSUM_LEN
              + (incompat_bits[0] ? SIGNATURE_LEN : 10'd0);
    known   = (extra_for(msg_reg) != 8'd0);
    checked = 1'b0;
    if (count < HEADER_LEN + CHECKSUM_LEN) err = ERR_SHORT;
    else if (!magic_good) err = ERR_MAGIC;
    else if (count < need) err = ERR_TRUNCATED;
    else begin
      checked = known;
      err     = (known && !match_next) ? ERR_CRC : ERR_OK;
    end
  end

  // Frame state: header capture and checksum, cleared after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_good    <= 1'b0;
      length_byte   <= 8'd0;
      incompat_bits <= 8'd0;
      seq_reg       <= 8'd0;
      sys_reg       <= 8'd0;
      comp_reg      <= 8'd0;
      msg_reg       <= 24'd0;
      running_crc   <= CRC_SEED;
      received_low  <= 8'd0;
      crc_match     <= 1'b0;
    end else if (pop) begin
      if (q_entry.last) begin
        magic_good    <= 1'b0;
        length_byte   <= 8'd0;
        incompat_bits <= 8'd0;
        seq_reg       <= 8'd0;
        sys_reg       <= 8'd0;
        comp_reg      <= 8'd0;
        msg_reg       <= 24'd0;
        running_crc   <= CRC_SEED;
        received_low  <= 8'd0;
        crc_match     <= 1'b0;
      end else begin
        if (q_entry.pos == 9'd0) magic_good <= (q_entry.data == MAGIC_V2);
        if (q_entry.pos == 9'd1) length_byte <= q_entry.data;
        if (q_entry.pos == 9'd2) incompat_bits <= q_entry.data;
        if (q_entry.pos == 9'd4) seq_reg <= q_entry.data;
        if (q_entry.pos == 9'd5) sys_reg <= q_entry.data;
        if (q_entry.pos == 9'd6) comp_reg <= q_entry.data;
        msg_reg     <= msg_next;
        running_crc <= crc_next;
        if (q_entry.cls.crc_lo) received_low <= q_entry.data;
        crc_match   <= match_next;
      end
    end
  end

  // Output register: holds a verdict until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_entry.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      frame_ok    <= (err == ERR_OK);
      error_code  <= err;
      crc_checked <= checked;
      if (err == ERR_OK) begin
        sequence_number <= seq_reg;
        system_id       <= sys_reg;
        component_id    <= comp_reg;
        message_id      <= msg_reg;
        payload_length  <= length_byte;
        is_signed       <= incompat_bits[0];
      end else begin
        sequence_number <= 8'd0;
        system_id       <= 8'd0;
        component_id    <= 8'd0;
        message_id      <= 24'd0;
        payload_length  <= 8'd0;
        is_signed       <= 1'b0;
      end
    end
  end

endmodule

### rtl/mavlink_v2_frame_checker_top.sv
// Channel  Handshake            Fields
// in       in_valid / in_stall   data_byte[7:0], last_byte
// out      out_valid / out_stall frame_ok, error_code[2:0], crc_checked, sequence_number[7:0],
//                                system_id[7:0], component_id[7:0], message_id[23:0],
//                                payload_length[7:0], is_signed
//
// One byte is taken per cycle while in_stall is low; the checksum step and the CRC-extra
// fold share one cycle. A verdict passes through the two-entry queue and then the output
// register. Reset is synchronous and clears the position count, queue and frame state.
// A stalled output holds the verdict; bytes keep flowing until the queue fills behind a
// second last byte.
module mavlink_v2_frame_checker_top import mvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_ok,
  output logic [2:0]  error_code,
  output logic        crc_checked,
  output logic [7:0]  sequence_number,
  output logic [7:0]  system_id,
  output logic [7:0]  component_id,
  output logic [23:0] message_id,
  output logic [7:0]  payload_length,
  output logic        is_signed
);

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   q_valid;
  entry_t q_entry;
  logic   pop;

  assign in_stall = full;

  // Front part: position count and byte classification.
  mvc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue between the two parts.
  mvc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  // Back part: header capture, checksum and verdict.
  mvc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_ok        (frame_ok),
    .error_code      (error_code),
    .crc_checked     (crc_checked),
    .sequence_number (sequence_number),
    .system_id       (system_id),
    .component_id    (component_id),
    .message_id      (message_id),
    .payload_length  (payload_length),
    .is_signed       (is_signed)
  );

endmodule
